// File: rtl/core/pca_pkg.sv
// Shared types and constants for the pixel colour adjustment pipeline.
package pca_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  // Live settings as seen by the datapath; channel count already decoded.
  typedef struct packed {
    logic signed [8:0]  bright;
    logic signed [11:0] con;
    logic signed [11:0] sat;
    logic signed [8:0]  temp;
    logic [3:0]         ch_mask;
    logic               rgb_mode;
  } cfg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 3'd4;

  // Luma weights, Q0.16, summing to 65536.
  localparam logic [16:0] W_RED   = 17'd19595;
  localparam logic [16:0] W_GREEN = 17'd38470;
  localparam logic [16:0] W_BLUE  = 17'd7471;

  localparam logic signed [13:0] MID_LEVEL = 14'sd128;

  function automatic logic [7:0] clamp8(input logic signed [39:0] v);
    logic [7:0] r;
    if (v < 40'sd0) begin
      r = 8'd0;
    end else if (v > 40'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pca_tone.sv
// Brightness and contrast stages, three register stages over four lanes.
module pca_tone
  import pca_pkg::*;
(
  input  logic            clk,
  input  logic [2:0]      en,
  input  cfg_t            cfg,
  input  pix_in_t         din,
  output logic [3:0][7:0] dout
);

  logic [3:0][7:0]   lane_in;
  logic [7:0]        v1_r [4];
  logic signed [20:0] p2_r [4];
  logic [3:0][7:0]   v3_r;

  logic signed [9:0]  sum1 [4];
  logic signed [8:0]  cen2 [4];
  logic signed [20:0] p2_nxt [4];
  logic signed [13:0] t3 [4];

  assign lane_in = {din.alpha_in, din.blue_in, din.green_in, din.red_in};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum1[i]   = $signed({2'b00, lane_in[i]}) + $signed({cfg.bright[8], cfg.bright});
      cen2[i]   = $signed({1'b0, v1_r[i]}) - 9'sd128;
      p2_nxt[i] = cen2[i] * cfg.con;
      t3[i]     = MID_LEVEL + 14'(p2_r[i] >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (en[0]) begin
        v1_r[i] <= clamp8(40'(sum1[i]));
      end
      if (en[1]) begin
        p2_r[i] <= p2_nxt[i];
      end
      if (en[2]) begin
        v3_r[i] <= cfg.ch_mask[i] ? clamp8(40'(t3[i])) : 8'd0;
      end
    end
  end

  assign dout = v3_r;

endmodule

// File: rtl/core/pca_sat.sv
// Saturation stages: luma products, differences, gain multiply, recombine.
module pca_sat
  import pca_pkg::*;
(
  input  logic            clk,
  input  logic [3:0]      en,
  input  cfg_t            cfg,
  input  logic [3:0][7:0] din,
  output logic [3:0][7:0] dout
);

  logic [3:0][7:0]    ch4_r, ch5_r, ch6_r, ch7_r;
  logic [23:0]        prod4_r [3];
  logic [23:0]        g5_r, g6_r;
  logic signed [24:0] d5_r [3];
  logic signed [36:0] m6_r [3];

  logic [23:0]        g_sum;
  logic signed [37:0] acc7 [3];

  assign g_sum = prod4_r[0] + prod4_r[1] + prod4_r[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc7[i] = $signed({6'b0, g6_r, 8'b0}) + 38'(m6_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ch4_r      <= din;
      prod4_r[0] <= W_RED   * din[0];
      prod4_r[1] <= W_GREEN * din[1];
      prod4_r[2] <= W_BLUE  * din[2];
    end
    if (en[1]) begin
      ch5_r <= ch4_r;
      g5_r  <= g_sum;
      for (int i = 0; i < 3; i++) begin
        d5_r[i] <= $signed({1'b0, ch4_r[i], 16'b0}) - $signed({1'b0, g_sum});
      end
    end
    if (en[2]) begin
      ch6_r <= ch5_r;
      g6_r  <= g5_r;
      for (int i = 0; i < 3; i++) begin
        m6_r[i] <= d5_r[i] * cfg.sat;
      end
    end
    if (en[3]) begin
      ch7_r[3] <= ch6_r[3];
      for (int i = 0; i < 3; i++) begin
        ch7_r[i] <= cfg.rgb_mode ? clamp8(40'(acc7[i] >>> 24)) : ch6_r[i];
      end
    end
  end

  assign dout = ch7_r;

endmodule

// File: rtl/core/pixel_color_adjust_chain.sv
// Top level: settings registers, stage flow control and temperature output stage.
// Pipeline of 8 stages; out_valid is the valid flag of the last of them.
// Throughput: one item per cycle; a stalled output backs up stage by stage, bubbles close.
// in_stall rises only when all eight stages hold items and the output is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and restores default settings.
module pixel_color_adjust_chain
  import pca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = 8;

  logic [8:0]  bright_r;
  logic [11:0] con_r;
  logic [11:0] sat_r;
  logic [8:0]  temp_r;
  logic [2:0]  nch_r;
  cfg_t        cfg;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] en;

  logic [3:0][7:0]    tone_q, sat_q;
  logic signed [10:0] red_t, blue_t;
  pix_out_t           out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= '0;
      con_r    <= 12'd256;
      sat_r    <= 12'd256;
      temp_r   <= '0;
      nch_r    <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BRIGHTNESS:  bright_r <= cfg_data[8:0];
        CFG_CONTRAST:    con_r    <= cfg_data;
        CFG_SATURATION:  sat_r    <= cfg_data;
        CFG_TEMPERATURE: temp_r   <= cfg_data[8:0];
        CFG_CHANNELS:    nch_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.bright   = $signed(bright_r);
    cfg.con      = $signed(con_r);
    cfg.sat      = $signed(sat_r);
    cfg.temp     = $signed(temp_r);
    cfg.rgb_mode = (nch_r >= 3'd3);
    unique case (nch_r)
      3'd0, 3'd1: cfg.ch_mask = 4'b0001;
      3'd2:       cfg.ch_mask = 4'b0011;
      3'd3:       cfg.ch_mask = 4'b0111;
      default:    cfg.ch_mask = 4'b1111;
    endcase
  end

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  pca_tone u_tone (
    .clk  (clk),
    .en   (en[2:0]),
    .cfg  (cfg),
    .din  (in_data),
    .dout (tone_q)
  );

  pca_sat u_sat (
    .clk  (clk),
    .en   (en[6:3]),
    .cfg  (cfg),
    .din  (tone_q),
    .dout (sat_q)
  );

  assign red_t  = $signed({3'b000, sat_q[0]}) + 11'(cfg.temp);
  assign blue_t = $signed({3'b000, sat_q[2]}) - 11'(cfg.temp);

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_r.red_out   <= cfg.rgb_mode ? clamp8(40'(red_t)) : sat_q[0];
      out_r.green_out <= sat_q[1];
      out_r.blue_out  <= cfg.rgb_mode ? clamp8(40'(blue_t)) : sat_q[2];
      out_r.alpha_out <= sat_q[3];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

endmodule

// File: rtl/core/pca_checker.sv
// Port-level checker for the colour adjustment pipeline, with its bind.
module pca_checker
  import pca_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pix_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item dropped or changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input item withdrawn");

endmodule

bind pixel_color_adjust_chain pca_checker u_pca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
